FILE: hdl/smc_pkg.sv
// smc_pkg: shared types and constants of the sprite mask collision block.
// Holds operation codes, the shape header layout and the scan window word.
// No dependencies.
package smc_pkg;

    // Operation codes carried on i_operation
    localparam logic [1:0] OP_HDR_WR = 2'd0;
    localparam logic [1:0] OP_ROW_WR = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Shape index field spans 64 shapes
    localparam int SHAPE_SPAN = 64;

    // Box coordinates inside shape A: 0..127 (7-bit width and height)
    localparam int COORD_W = 7;
    localparam int SPAN_W  = 128;

    // Relative box position: offset plus two origins, signed
    localparam int REL_W = 18;

    // One shape header word
    typedef struct packed {
        logic [6:0]         width;
        logic [6:0]         height;
        logic signed [12:0] origin_x;
        logic signed [12:0] origin_y;
        logic               pixel_perfect;
    } t_hdr;

    // Scan window in shape A coordinates, plus B alignment shifts
    typedef struct packed {
        logic                box_hit;
        logic                pp_a;
        logic                pp_b;
        logic [COORD_W-1:0]  cx1;
        logic [COORD_W-1:0]  cx2;
        logic [COORD_W-1:0]  cy1;
        logic [COORD_W-1:0]  cy2;
        logic signed [7:0]   sx;
        logic signed [7:0]   sy;
    } t_win;

endpackage

FILE: hdl/smc_ram.sv
// smc_ram: generic single-clock RAM, one write port, two registered read ports.
// Used for the shape header table and the mask row store.
// No dependencies.
module smc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads
    always_ff @(posedge i_clk) begin
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

FILE: hdl/smc_geom.sv
// smc_geom: two-stage box geometry for a query.
// Stage one forms B's box position relative to A; stage two runs the inclusive
// box test and clips the scan window. Depends on smc_pkg.
module smc_geom (
    input  logic               i_clk,
    input  logic               i_ld_rel,
    input  logic               i_ld_win,
    input  smc_pkg::t_hdr      i_hdr_a,
    input  smc_pkg::t_hdr      i_hdr_b,
    input  logic signed [15:0] i_dx,
    input  logic signed [15:0] i_dy,
    output smc_pkg::t_win      o_win
);

    logic signed [smc_pkg::REL_W-1:0] r_rbx1;
    logic signed [smc_pkg::REL_W-1:0] r_rby1;
    logic [6:0]                       r_wa;
    logic [6:0]                       r_ha;
    logic [6:0]                       r_wb;
    logic [6:0]                       r_hb;
    logic                             r_ppa;
    logic                             r_ppb;
    smc_pkg::t_win                    r_win;

    logic signed [smc_pkg::REL_W-1:0] rbx2;
    logic signed [smc_pkg::REL_W-1:0] rby2;
    logic signed [smc_pkg::REL_W-1:0] wa_s;
    logic signed [smc_pkg::REL_W-1:0] ha_s;
    logic                             box_x;
    logic                             box_y;
    smc_pkg::t_win                    n_win;

    // stage one: B box start relative to A box start (dx - oxB + oxA)
    always_ff @(posedge i_clk) begin
        if (i_ld_rel) begin
            r_rbx1 <= $signed({{2{i_dx[15]}}, i_dx})
                    - $signed({{5{i_hdr_b.origin_x[12]}}, i_hdr_b.origin_x})
                    + $signed({{5{i_hdr_a.origin_x[12]}}, i_hdr_a.origin_x});
            r_rby1 <= $signed({{2{i_dy[15]}}, i_dy})
                    - $signed({{5{i_hdr_b.origin_y[12]}}, i_hdr_b.origin_y})
                    + $signed({{5{i_hdr_a.origin_y[12]}}, i_hdr_a.origin_y});
            r_wa   <= i_hdr_a.width;
            r_ha   <= i_hdr_a.height;
            r_wb   <= i_hdr_b.width;
            r_hb   <= i_hdr_b.height;
            r_ppa  <= i_hdr_a.pixel_perfect;
            r_ppb  <= i_hdr_b.pixel_perfect;
        end
    end

    // stage two: inclusive box test and half-open window clip
    always_comb begin
        wa_s  = $signed({11'b0, r_wa});
        ha_s  = $signed({11'b0, r_ha});
        rbx2  = r_rbx1 + $signed({11'b0, r_wb});
        rby2  = r_rby1 + $signed({11'b0, r_hb});
        box_x = (r_rbx1 <= wa_s) && !rbx2[smc_pkg::REL_W-1];
        box_y = (r_rby1 <= ha_s) && !rby2[smc_pkg::REL_W-1];

        n_win.box_hit = box_x && box_y;
        n_win.pp_a    = r_ppa;
        n_win.pp_b    = r_ppb;
        // start values fit 7 bits once the box test passes
        n_win.cx1 = r_rbx1[smc_pkg::REL_W-1] ? '0 : r_rbx1[smc_pkg::COORD_W-1:0];
        n_win.cy1 = r_rby1[smc_pkg::REL_W-1] ? '0 : r_rby1[smc_pkg::COORD_W-1:0];
        n_win.cx2 = (rbx2 > wa_s) ? r_wa : rbx2[smc_pkg::COORD_W-1:0];
        n_win.cy2 = (rby2 > ha_s) ? r_ha : rby2[smc_pkg::COORD_W-1:0];
        // B alignment shift, within +-127 whenever the window is non-empty
        n_win.sx  = r_rbx1[7:0];
        n_win.sy  = r_rby1[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ld_win) begin
            r_win <= n_win;
        end
    end

    assign o_win = r_win;

endmodule

FILE: hdl/smc_row_hit.sv
// smc_row_hit: tests one scan row for an overlapping opaque pixel.
// Holds the column window mask; aligns B's row to A's columns.
// Depends on smc_pkg.
module smc_row_hit #(
    parameter int MAX_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_ld,
    input  smc_pkg::t_win        i_win,
    input  logic [MAX_WIDTH-1:0] i_row_a,
    input  logic [MAX_WIDTH-1:0] i_row_b,
    input  logic                 i_a_ok,
    input  logic                 i_b_ok,
    output logic                 o_hit
);

    localparam int SW = smc_pkg::SPAN_W;

    logic [SW-1:0] r_colmask;
    logic [SW-1:0] ones;
    logic [SW-1:0] pa;
    logic [SW-1:0] pb;
    logic [SW-1:0] b_ext;
    logic [SW-1:0] b_al;
    logic [7:0]    sx_neg;

    assign ones = '1;

    // columns cx1 <= x < cx2 in A coordinates
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_colmask <= (ones << i_win.cx1) & ~(ones << i_win.cx2);
        end
    end

    always_comb begin
        // A row: box-only shapes are fully opaque, rows past the store are clear
        if (!i_win.pp_a) begin
            pa = '1;
        end else if (i_a_ok) begin
            pa = SW'(i_row_a);
        end else begin
            pa = '0;
        end

        // B row shifted so B column xb lands on A column xb + sx
        sx_neg = 8'(-i_win.sx);
        b_ext  = SW'(i_row_b);
        b_al   = i_win.sx[7] ? (b_ext >> sx_neg[6:0]) : (b_ext << i_win.sx[6:0]);
        if (!i_win.pp_b) begin
            pb = '1;
        end else if (i_b_ok) begin
            pb = b_al;
        end else begin
            pb = '0;
        end
    end

    assign o_hit = |(pa & pb & r_colmask);

endmodule

FILE: hdl/sprite_mask_collision.sv
// Sprite mask collision: header and row writes give no result, busy stays low.
// A query with a shape out of range answers on o_strobe straight from idle; a box-only
// decision answers from S_PREP, after S_HDR and S_GEO; a mask scan then runs in S_SCAN
// over R rows (at most 127, one mask row word per cycle, stopping at the first hit).
// busy is high from in-range query start to the result word; o_strobe lasts one cycle.
// Reset (synchronous, i_rst_n low) clears the header valid flags; mask rows stay undefined.
module sprite_mask_collision #(
    parameter int NUM_SHAPES = 64,
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_shape_a,
    input  logic [5:0]  i_shape_b,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic [6:0]  i_width,
    input  logic [6:0]  i_height,
    input  logic signed [12:0] i_origin_x,
    input  logic signed [12:0] i_origin_y,
    input  logic        i_pixel_perfect,
    input  logic [5:0]  i_row_index,
    input  logic [63:0] i_row_bits,
    output logic        o_strobe,
    output logic        o_collided
);

    localparam int HDR_DEPTH  = (NUM_SHAPES < smc_pkg::SHAPE_SPAN) ? NUM_SHAPES
                                                                 : smc_pkg::SHAPE_SPAN;
    localparam int HIDX_W     = (HDR_DEPTH > 1) ? $clog2(HDR_DEPTH) : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MASK_DEPTH = 1 << (HIDX_W + ROW_W);
    localparam int HDR_W      = $bits(smc_pkg::t_hdr);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HDR  = 5'b00010,
        S_GEO  = 5'b00100,
        S_PREP = 5'b01000,
        S_SCAN = 5'b10000
    } t_state;

    // control registers
    t_state               r_state, n_state;
    logic [HDR_DEPTH-1:0] r_hdr_vld;
    logic [smc_pkg::COORD_W-1:0] r_y, n_y;
    logic                 r_pend, n_pend;
    logic                 r_strobe, n_strobe;
    logic                 r_collided, n_collided;

    // query payload registers
    logic [HIDX_W-1:0]    r_sa;
    logic [HIDX_W-1:0]    r_sb;
    logic signed [15:0]   r_dx;
    logic signed [15:0]   r_dy;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_a_ok;
    logic                 r_b_ok;

    logic                 accept;
    logic                 a_in;
    logic                 b_in;
    logic                 row_in;
    logic                 hdr_we;
    logic                 mask_we;
    smc_pkg::t_hdr        hdr_wdata;
    logic [HDR_W-1:0]     hdr_rd0;
    logic [HDR_W-1:0]     hdr_rd1;
    smc_pkg::t_hdr        hdr_a;
    smc_pkg::t_hdr        hdr_b;
    smc_pkg::t_win        win;
    logic [MAX_WIDTH-1:0] row_a;
    logic [MAX_WIDTH-1:0] row_b;
    logic [8:0]           wr_row9;
    logic [8:0]           y9;
    logic [8:0]           yb9;
    logic                 a_ok_n;
    logic                 b_ok_n;
    logic                 row_hit;
    logic [HIDX_W+ROW_W-1:0] mask_waddr;
    logic [HIDX_W+ROW_W-1:0] mask_raddr0;
    logic [HIDX_W+ROW_W-1:0] mask_raddr1;

    // input decode
    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign a_in    = int'(i_shape_a) < NUM_SHAPES;
    assign b_in    = int'(i_shape_b) < NUM_SHAPES;
    assign row_in  = int'(i_row_index) < MAX_HEIGHT;
    assign hdr_we  = accept && (i_operation == smc_pkg::OP_HDR_WR) && a_in;
    assign mask_we = accept && (i_operation == smc_pkg::OP_ROW_WR) && a_in && row_in;

    always_comb begin
        hdr_wdata.width         = i_width;
        hdr_wdata.height        = i_height;
        hdr_wdata.origin_x      = i_origin_x;
        hdr_wdata.origin_y      = i_origin_y;
        hdr_wdata.pixel_perfect = i_pixel_perfect;
    end

    // header table; reads follow the query word directly (data due in S_HDR)
    smc_ram #(
        .WIDTH (HDR_W),
        .DEPTH (HDR_DEPTH)
    ) u_hdr_ram (
        .i_clk    (i_clk),
        .i_we     (hdr_we),
        .i_waddr  (i_shape_a[HIDX_W-1:0]),
        .i_wdata  (hdr_wdata),
        .i_raddr0 (i_shape_a[HIDX_W-1:0]),
        .i_raddr1 (i_shape_b[HIDX_W-1:0]),
        .o_rdata0 (hdr_rd0),
        .o_rdata1 (hdr_rd1)
    );

    // an unwritten header reads as all zero
    assign hdr_a = r_va ? smc_pkg::t_hdr'(hdr_rd0) : '0;
    assign hdr_b = r_vb ? smc_pkg::t_hdr'(hdr_rd1) : '0;

    smc_geom u_geom (
        .i_clk    (i_clk),
        .i_ld_rel (r_state == S_HDR),
        .i_ld_win (r_state == S_GEO),
        .i_hdr_a  (hdr_a),
        .i_hdr_b  (hdr_b),
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .o_win    (win)
    );

    // mask row addressing: {shape, row}; B's row is y minus its vertical shift
    assign wr_row9     = {3'b0, i_row_index};
    assign mask_waddr  = {i_shape_a[HIDX_W-1:0], wr_row9[ROW_W-1:0]};
    assign y9          = {2'b0, r_y};
    assign yb9         = y9 - {win.sy[7], win.sy};
    assign mask_raddr0 = {r_sa, y9[ROW_W-1:0]};
    assign mask_raddr1 = {r_sb, yb9[ROW_W-1:0]};
    assign a_ok_n      = int'(r_y) < MAX_HEIGHT;
    assign b_ok_n      = !yb9[8] && (int'(yb9[7:0]) < MAX_HEIGHT);

    // mask store; writes happen only while idle, so a scan never reads a row
    // that is being written
    smc_ram #(
        .WIDTH (MAX_WIDTH),
        .DEPTH (MASK_DEPTH)
    ) u_mask_ram (
        .i_clk    (i_clk),
        .i_we     (mask_we),
        .i_waddr  (mask_waddr),
        .i_wdata  (i_row_bits[MAX_WIDTH-1:0]),
        .i_raddr0 (mask_raddr0),
        .i_raddr1 (mask_raddr1),
        .o_rdata0 (row_a),
        .o_rdata1 (row_b)
    );

    smc_row_hit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_hit (
        .i_clk   (i_clk),
        .i_ld    (r_state == S_PREP),
        .i_win   (win),
        .i_row_a (row_a),
        .i_row_b (row_b),
        .i_a_ok  (r_a_ok),
        .i_b_ok  (r_b_ok),
        .o_hit   (row_hit)
    );

    // query sequencer
    always_comb begin
        n_state    = r_state;
        n_y        = r_y;
        n_pend     = 1'b0;
        n_strobe   = 1'b0;
        n_collided = r_collided;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_operation == smc_pkg::OP_QUERY)) begin
                    if (a_in && b_in) begin
                        n_state = S_HDR;
                    end else begin
                        n_strobe   = 1'b1;
                        n_collided = 1'b0;
                    end
                end
            end
            S_HDR: begin
                n_state = S_GEO;
            end
            S_GEO: begin
                n_state = S_PREP;
            end
            S_PREP: begin
                if (!win.box_hit) begin
                    n_strobe   = 1'b1;
                    n_collided = 1'b0;
                    n_state    = S_IDLE;
                end else if (!win.pp_a && !win.pp_b) begin
                    n_strobe   = 1'b1;
                    n_collided = 1'b1;
                    n_state    = S_IDLE;
                end else if ((win.cx1 >= win.cx2) || (win.cy1 >= win.cy2)) begin
                    n_strobe   = 1'b1;
                    n_collided = 1'b0;
                    n_state    = S_IDLE;
                end else begin
                    n_y     = win.cy1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one row read per cycle, test the row read last cycle
                if (r_pend && row_hit) begin
                    n_strobe   = 1'b1;
                    n_collided = 1'b1;
                    n_state    = S_IDLE;
                end else if (r_y < win.cy2) begin
                    n_pend = 1'b1;
                    n_y    = r_y + 1'b1;
                end else if (!r_pend) begin
                    n_strobe   = 1'b1;
                    n_collided = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_hdr_vld  <= '0;
            r_y        <= '0;
            r_pend     <= 1'b0;
            r_strobe   <= 1'b0;
            r_collided <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_y        <= n_y;
            r_pend     <= n_pend;
            r_strobe   <= n_strobe;
            r_collided <= n_collided;
            if (hdr_we) begin
                r_hdr_vld[i_shape_a[HIDX_W-1:0]] <= 1'b1;
            end
        end
    end

    // query payload capture and row flags
    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == smc_pkg::OP_QUERY) && a_in && b_in) begin
            r_sa <= i_shape_a[HIDX_W-1:0];
            r_sb <= i_shape_b[HIDX_W-1:0];
            r_dx <= i_offset_x;
            r_dy <= i_offset_y;
            r_va <= r_hdr_vld[i_shape_a[HIDX_W-1:0]];
            r_vb <= r_hdr_vld[i_shape_b[HIDX_W-1:0]];
        end
        r_a_ok <= a_ok_n;
        r_b_ok <= b_ok_n;
    end

    assign o_strobe   = r_strobe;
    assign o_collided = r_collided;

endmodule

FILE: hdl/smc_checker.sv
// smc_checker: port-level checks of the sprite mask collision command interface.
// Bound to sprite_mask_collision below. Depends on smc_pkg.
module smc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_strobe
);

    // result word never shows while a query is still running
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // a running query always ends in a result word
    a_fell_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("busy dropped without a result");

    // an accepted query starts work or answers at once
    a_query_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == smc_pkg::OP_QUERY) |=> (busy || o_strobe))
        else $error("query accepted but neither busy nor answered");

    // writes and unused codes give no result and no busy time
    a_write_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != smc_pkg::OP_QUERY) |=> (!busy && !o_strobe))
        else $error("write produced busy or result");

    // every result word comes from a query
    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($fell(busy) ||
                      $past(start && !busy && i_operation == smc_pkg::OP_QUERY)))
        else $error("result without a query");

endmodule

bind sprite_mask_collision smc_checker u_smc_checker (.*);

FILE: test/tb_top.sv
// tb_top: self-checking bench for sprite_mask_collision (header, row and query words).
// Holds its own shape table and mask store and predicts each collision answer.
// Depends on smc_pkg and the sprite_mask_collision RTL.
`timescale 1ns / 1ps

module tb_top;

    // Operation code that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int NUM_SHAPES   = 64;
    localparam int MASK_W       = 64;
    localparam int MASK_H       = 64;
    localparam int WATCH_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 140;
    localparam int WORD_TARGET  = 800;

    // One input word, every field of it
    typedef struct {
        logic [1:0]         op;
        logic [5:0]         sa;
        logic [5:0]         sb;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [6:0]         w;
        logic [6:0]         h;
        logic signed [12:0] ox;
        logic signed [12:0] oy;
        logic               pp;
        logic [5:0]         row;
        logic [63:0]        bits;
    } t_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_operation = '0;
    logic [5:0]         i_shape_a = '0;
    logic [5:0]         i_shape_b = '0;
    logic signed [15:0] i_offset_x = '0;
    logic signed [15:0] i_offset_y = '0;
    logic [6:0]         i_width = '0;
    logic [6:0]         i_height = '0;
    logic signed [12:0] i_origin_x = '0;
    logic signed [12:0] i_origin_y = '0;
    logic               i_pixel_perfect = 1'b0;
    logic [5:0]         i_row_index = '0;
    logic [63:0]        i_row_bits = '0;
    logic               o_strobe;
    logic               o_collided;

    // Shadow of the block's state
    smc_pkg::t_hdr shape_tab [NUM_SHAPES];
    logic [63:0]   mask_tab  [NUM_SHAPES][MASK_H];

    // Pending collision answers, oldest first
    bit          hit_q [$];
    bit          hit_exp;
    int          err_cnt   = 0;
    int          words_in  = 0;
    int          idle_cnt  = 0;
    int          burst_left = 0;

    sprite_mask_collision DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_shape_a       (i_shape_a),
        .i_shape_b       (i_shape_b),
        .i_offset_x      (i_offset_x),
        .i_offset_y      (i_offset_y),
        .i_width         (i_width),
        .i_height        (i_height),
        .i_origin_x      (i_origin_x),
        .i_origin_y      (i_origin_y),
        .i_pixel_perfect (i_pixel_perfect),
        .i_row_index     (i_row_index),
        .i_row_bits      (i_row_bits),
        .o_strobe        (o_strobe),
        .o_collided      (o_collided)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Opaque test on one mask pixel; outside the store is transparent
    function automatic bit mask_pixel(int s, int x, int y);
        if (x < 0 || y < 0 || x >= MASK_W || y >= MASK_H)
            return 1'b0;
        return mask_tab[s][y][x];
    endfunction

    // Box test, then mask scan over the half-open intersection
    function automatic bit shapes_collide(int sa, int sb, int dx, int dy);
        smc_pkg::t_hdr ha, hb;
        int   ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
        int   cx1, cx2, cy1, cy2;
        bit   pa, pb;
        ha  = shape_tab[sa];
        hb  = shape_tab[sb];
        ax1 = -int'($signed(ha.origin_x));
        ay1 = -int'($signed(ha.origin_y));
        ax2 = ax1 + int'(ha.width);
        ay2 = ay1 + int'(ha.height);
        bx1 = dx - int'($signed(hb.origin_x));
        by1 = dy - int'($signed(hb.origin_y));
        bx2 = bx1 + int'(hb.width);
        by2 = by1 + int'(hb.height);
        if (!(ax2 >= bx1 && ax1 <= bx2 && ay2 >= by1 && ay1 <= by2))
            return 1'b0;
        if (!ha.pixel_perfect && !hb.pixel_perfect)
            return 1'b1;
        // move B into A's corner frame
        bx1 -= ax1; bx2 -= ax1;
        by1 -= ay1; by2 -= ay1;
        cx1 = (bx1 > 0) ? bx1 : 0;
        cx2 = (bx2 < int'(ha.width)) ? bx2 : int'(ha.width);
        cy1 = (by1 > 0) ? by1 : 0;
        cy2 = (by2 < int'(ha.height)) ? by2 : int'(ha.height);
        for (int y = cy1; y < cy2; y++) begin
            for (int x = cx1; x < cx2; x++) begin
                pa = ha.pixel_perfect ? mask_pixel(sa, x, y) : 1'b1;
                pb = hb.pixel_perfect ? mask_pixel(sb, x - bx1, y - by1) : 1'b1;
                if (pa && pb)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Update the shadow state for an accepted word
    function automatic void apply_word(t_word c);
        case (c.op)
            smc_pkg::OP_HDR_WR: begin
                shape_tab[c.sa] = '{width: c.w, height: c.h, origin_x: c.ox,
                                    origin_y: c.oy, pixel_perfect: c.pp};
            end
            smc_pkg::OP_ROW_WR: begin
                mask_tab[c.sa][c.row] = c.bits;
            end
            smc_pkg::OP_QUERY: begin
                hit_q.push_back(shapes_collide(c.sa, c.sb, c.dx, c.dy));
            end
            default: ;
        endcase
    endfunction

    // Every field random; callers override what matters
    function automatic t_word rand_word();
        t_word c;
        c.op   = 2'($urandom);
        c.sa   = 6'($urandom);
        c.sb   = 6'($urandom);
        c.dx   = 16'($urandom);
        c.dy   = 16'($urandom);
        c.w    = 7'($urandom);
        c.h    = 7'($urandom);
        c.ox   = 13'($urandom);
        c.oy   = 13'($urandom);
        c.pp   = 1'($urandom);
        c.row  = 6'($urandom);
        c.bits = {$urandom, $urandom};
        return c;
    endfunction

    // Sender idle cycles, with occasional back-to-back runs
    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Drive one word and hold it until the block takes it
    task automatic send_word(input t_word c);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_operation     <= c.op;
        i_shape_a       <= c.sa;
        i_shape_b       <= c.sb;
        i_offset_x      <= c.dx;
        i_offset_y      <= c.dy;
        i_width         <= c.w;
        i_height        <= c.h;
        i_origin_x      <= c.ox;
        i_origin_y      <= c.oy;
        i_pixel_perfect <= c.pp;
        i_row_index     <= c.row;
        i_row_bits      <= c.bits;
        do @(posedge i_clk); while (busy);
        apply_word(c);
        if (c.op != OP_UNUSED)
            words_in++;
    endtask

    task automatic write_header(input int s, input int w, input int h,
                                input int ox, input int oy, input bit pp);
        t_word c;
        c    = rand_word();
        c.op = smc_pkg::OP_HDR_WR;
        c.sa = 6'(s);
        c.w  = 7'(w);
        c.h  = 7'(h);
        c.ox = 13'(ox);
        c.oy = 13'(oy);
        c.pp = pp;
        send_word(c);
    endtask

    task automatic write_row(input int s, input int r, input logic [63:0] bits);
        t_word c;
        c      = rand_word();
        c.op   = smc_pkg::OP_ROW_WR;
        c.sa   = 6'(s);
        c.row  = 6'(r);
        c.bits = bits;
        send_word(c);
    endtask

    task automatic query_pair(input int sa, input int sb, input int dx, input int dy);
        t_word c;
        c    = rand_word();
        c.op = smc_pkg::OP_QUERY;
        c.sa = 6'(sa);
        c.sb = 6'(sb);
        c.dx = 16'(dx);
        c.dy = 16'(dy);
        send_word(c);
    endtask

    // Mask row content by density style
    function automatic logic [63:0] mask_word(int style);
        case (style)
            0: return '0;
            1: return ($urandom_range(0, 1) == 0) ? 64'd0 : (64'd1 << $urandom_range(0, 63));
            2: return {$urandom, $urandom};
            3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return '1;
        endcase
    endfunction

    // Header plus every mask row a scan of it could touch (one past the height too)
    task automatic build_shape(input int s, input int w, input int h,
                               input int ox, input int oy, input bit pp);
        int style;
        int last;
        style = $urandom_range(0, 4);
        last  = (h < MASK_H - 1) ? h : MASK_H - 1;
        if (pp) begin
            for (int r = 0; r <= last; r++)
                write_row(s, r, mask_word(style));
        end
        write_header(s, w, h, ox, oy, pp);
    endtask

    // Headers straight out of reset: zero-size boxes, inclusive edges
    task automatic test_reset_defaults();
        query_pair(0, 1, 0, 0);
        query_pair(0, 0, 1, 0);
    endtask

    // Unused operation code: no answer expected
    task automatic test_unused_op();
        t_word c;
        c    = rand_word();
        c.op = OP_UNUSED;
        send_word(c);
    endtask

    // Largest boxes, extreme origins and offsets
    task automatic test_box_extremes();
        write_header(2, 127, 127, -4096, 4095, 1'b0);
        write_header(3, 0, 0, 4095, -4096, 1'b0);
        query_pair(2, 3, 8191, -8191);
        query_pair(2, 3, -32768, 32767);
        query_pair(2, 3, 32767, -32768);
        query_pair(3, 2, -8318, 8064);
        query_pair(3, 2, -8319, 8064);
    endtask

    // Single and double mask scans, columns past the store, touching edges
    task automatic test_mask_scan();
        write_row(4, 0, 64'h8000_0000_0000_0000);
        write_row(4, 1, '0);
        write_header(4, 100, 1, 0, 0, 1'b1);
        write_header(5, 1, 1, 0, 0, 1'b0);
        write_row(6, 0, 64'h1);
        write_row(6, 1, '0);
        write_header(6, 2, 1, 0, 0, 1'b1);
        query_pair(4, 5, 63, 0);
        query_pair(4, 5, 70, 0);
        query_pair(4, 5, 100, 0);
        query_pair(4, 6, 62, 0);
        query_pair(4, 6, 63, 0);
    endtask

    // Random shapes, mostly overlapping queries, some noise
    task automatic test_random_traffic();
        int   pick, s, sa, sb, w, h, ox, oy, rel_x, rel_y, dx, dy;
        t_word c;
        for (int i = 0; i < 8; i++) begin
            s = $urandom_range(0, 15);
            build_shape(s, $urandom_range(1, 16), $urandom_range(1, 12),
                        int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8,
                        1'($urandom_range(0, 4) != 0));
        end
        while (words_in < WORD_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                sa = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
                sb = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
                if ($urandom_range(0, 9) == 0) begin
                    dx = int'($signed(16'($urandom)));
                    dy = int'($signed(16'($urandom)));
                end else begin
                    // aim B near A's box so the scan has work to do
                    rel_x = int'($urandom_range(0, shape_tab[sa].width + shape_tab[sb].width + 4))
                            - int'(shape_tab[sb].width) - 2;
                    rel_y = int'($urandom_range(0, shape_tab[sa].height + shape_tab[sb].height + 4))
                            - int'(shape_tab[sb].height) - 2;
                    dx = rel_x + int'($signed(shape_tab[sb].origin_x))
                         - int'($signed(shape_tab[sa].origin_x));
                    dy = rel_y + int'($signed(shape_tab[sb].origin_y))
                         - int'($signed(shape_tab[sa].origin_y));
                end
                query_pair(sa, sb, dx, dy);
            end else if (pick < 85) begin
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
                case ($urandom_range(0, 9))
                    0:       w = $urandom_range(65, 127);
                    1:       w = $urandom_range(0, 64);
                    default: w = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 19))
                    0:          h = $urandom_range(65, 127);
                    1, 2, 3:    h = $urandom_range(13, 64);
                    default:    h = $urandom_range(1, 12);
                endcase
                if ($urandom_range(0, 6) == 0) begin
                    ox = int'($signed(13'($urandom)));
                    oy = int'($signed(13'($urandom)));
                end else begin
                    ox = int'($urandom_range(0, 16)) - 8;
                    oy = int'($urandom_range(0, 16)) - 8;
                end
                build_shape(s, w, h, ox, oy, 1'($urandom_range(0, 4) < 3));
            end else if (pick < 95) begin
                write_row($urandom_range(0, 63), $urandom_range(0, 63), mask_word($urandom_range(0, 4)));
            end else begin
                c    = rand_word();
                c.op = OP_UNUSED;
                send_word(c);
            end
        end
    endtask

    // Result checker: one answer per strobe, in order
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (hit_q.size() == 0) begin
                $error("collided: unexpected result word, actual %0b", o_collided);
                err_cnt++;
            end else begin
                hit_exp = hit_q.pop_front();
                if (o_collided !== hit_exp) begin
                    $error("collided: expected %0b, actual %0b", hit_exp, o_collided);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: too long with no word taken and no answer given
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCH_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < NUM_SHAPES; s++)
            shape_tab[s] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_unused_op();
        test_box_extremes();
        test_mask_scan();
        test_random_traffic();

        // drain outstanding answers, then let the block settle
        start <= 1'b0;
        while (hit_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
